// ===== hdl/rvcore_pkg.sv =====
// Package for the RV32I step core: opcodes, function codes and the
// decoded-item struct passed from the front end to the back end.
// No dependencies.
package rvcore_pkg;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] F7_BASE    = 7'b0000000;
    localparam logic [6:0] F7_ALT     = 7'b0100000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ILLEGAL   = 2'd1;
    localparam logic [1:0] ST_MISALIGN  = 2'd2;

    // Operation classes chosen by the front end.
    typedef enum logic [2:0] {
        K_ILLEGAL,
        K_LUI,
        K_AUIPC,
        K_JAL,
        K_JALR,
        K_BRANCH,
        K_ALU
    } t_kind;

    typedef enum logic [3:0] {
        A_ADD, A_SUB, A_SLL, A_SLT, A_SLTU, A_XOR, A_SRL, A_SRA, A_OR, A_AND
    } t_aluop;

    // One classified item.
    typedef struct packed {
        t_kind       kind;
        t_aluop      aluop;
        logic        use_imm;
        logic [2:0]  f3;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  rd;
        logic [31:0] imm;
    } t_dec;

endpackage

// ===== hdl/rvcore_front.sv =====
// Front end: accepts instruction items, decodes them into t_dec and
// pushes them into a two-entry queue. Depends on rvcore_pkg.
module rvcore_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_instruction,
    output logic               o_dec_valid,
    input  logic               i_dec_ready,
    output rvcore_pkg::t_dec   o_dec
);
    import rvcore_pkg::*;

    t_dec       w_dec;
    t_dec       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    logic [6:0] w_opc;
    logic [6:0] w_f7;
    logic [2:0] w_f3;
    logic [31:0] w_ins;

    assign w_ins = i_instruction;
    assign w_opc = w_ins[6:0];
    assign w_f3  = w_ins[14:12];
    assign w_f7  = w_ins[31:25];

    // Decode one instruction word.
    always_comb begin
        w_dec         = '0;
        w_dec.kind    = K_ILLEGAL;
        w_dec.aluop   = A_ADD;
        w_dec.f3      = w_f3;
        w_dec.rs1     = w_ins[19:15];
        w_dec.rs2     = w_ins[24:20];
        w_dec.rd      = w_ins[11:7];
        w_dec.use_imm = 1'b1;
        w_dec.imm     = {{20{w_ins[31]}}, w_ins[31:20]};
        case (w_opc)
            OPC_LUI: begin
                w_dec.kind = K_LUI;
                w_dec.imm  = {w_ins[31:12], 12'b0};
            end
            OPC_AUIPC: begin
                w_dec.kind = K_AUIPC;
                w_dec.imm  = {w_ins[31:12], 12'b0};
            end
            OPC_JAL: begin
                w_dec.kind = K_JAL;
                w_dec.imm  = {{12{w_ins[31]}}, w_ins[19:12], w_ins[20],
                              w_ins[30:21], 1'b0};
            end
            OPC_JALR: begin
                if (w_f3 == 3'd0) w_dec.kind = K_JALR;
            end
            OPC_BRANCH: begin
                if (w_f3 != 3'd2 && w_f3 != 3'd3) w_dec.kind = K_BRANCH;
                w_dec.imm = {{20{w_ins[31]}}, w_ins[7], w_ins[30:25],
                             w_ins[11:8], 1'b0};
            end
            OPC_OPIMM: begin
                w_dec.kind = K_ALU;
                case (w_f3)
                    3'd0: w_dec.aluop = A_ADD;
                    3'd2: w_dec.aluop = A_SLT;
                    3'd3: w_dec.aluop = A_SLTU;
                    3'd4: w_dec.aluop = A_XOR;
                    3'd6: w_dec.aluop = A_OR;
                    3'd7: w_dec.aluop = A_AND;
                    3'd1: begin
                        w_dec.aluop = A_SLL;
                        if (w_f7 != F7_BASE) w_dec.kind = K_ILLEGAL;
                    end
                    default: begin
                        if (w_f7 == F7_BASE) w_dec.aluop = A_SRL;
                        else if (w_f7 == F7_ALT) w_dec.aluop = A_SRA;
                        else w_dec.kind = K_ILLEGAL;
                    end
                endcase
            end
            OPC_OP: begin
                w_dec.kind    = K_ALU;
                w_dec.use_imm = 1'b0;
                if (w_f7 == F7_BASE) begin
                    case (w_f3)
                        3'd0:    w_dec.aluop = A_ADD;
                        3'd1:    w_dec.aluop = A_SLL;
                        3'd2:    w_dec.aluop = A_SLT;
                        3'd3:    w_dec.aluop = A_SLTU;
                        3'd4:    w_dec.aluop = A_XOR;
                        3'd5:    w_dec.aluop = A_SRL;
                        3'd6:    w_dec.aluop = A_OR;
                        default: w_dec.aluop = A_AND;
                    endcase
                end else if (w_f7 == F7_ALT && w_f3 == 3'd0) begin
                    w_dec.aluop = A_SUB;
                end else if (w_f7 == F7_ALT && w_f3 == 3'd5) begin
                    w_dec.aluop = A_SRA;
                end else begin
                    w_dec.kind = K_ILLEGAL;
                end
            end
            default: w_dec.kind = K_ILLEGAL;
        endcase
    end

    // Two-entry queue toward the back end.
    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_dec_valid = (r_cnt != 2'd0);
    assign w_pop       = o_dec_valid && i_dec_ready;
    assign o_dec       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_dec;
    end

endmodule

// ===== hdl/rvcore_back.sv =====
// Back end: executes decoded items against the register file and pc,
// and holds the result in an output register. Depends on rvcore_pkg.
module rvcore_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_dec_valid,
    output logic               o_dec_ready,
    input  rvcore_pkg::t_dec   i_dec,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_next_pc,
    output logic               o_write_enable,
    output logic [4:0]         o_dest_reg,
    output logic signed [31:0] o_write_value,
    output logic               o_branch_taken,
    output logic [1:0]         o_status
);
    import rvcore_pkg::*;

    logic [31:0] r_rf [32];
    logic [31:0] r_pc;
    logic        r_ov;
    logic [31:0] w_a, w_b, w_op2, w_alu, w_npc, w_val, w_pc4;
    logic        w_wr, w_taken, w_ok, w_cond, w_lts, w_ltu, w_fire;
    logic [4:0]  w_sh;
    logic [1:0]  w_st;

    // Register reads with x0 forced to zero.
    assign w_a   = (i_dec.rs1 == 5'd0) ? 32'd0 : r_rf[i_dec.rs1];
    assign w_b   = (i_dec.rs2 == 5'd0) ? 32'd0 : r_rf[i_dec.rs2];
    assign w_op2 = i_dec.use_imm ? i_dec.imm : w_b;
    assign w_sh  = w_op2[4:0];
    assign w_lts = $signed(w_a) < $signed(w_op2);
    assign w_ltu = w_a < w_op2;
    assign w_pc4 = r_pc + 32'd4;

    // ALU.
    always_comb begin
        case (i_dec.aluop)
            A_ADD:   w_alu = w_a + w_op2;
            A_SUB:   w_alu = w_a - w_op2;
            A_SLL:   w_alu = w_a << w_sh;
            A_SLT:   w_alu = {31'd0, w_lts};
            A_SLTU:  w_alu = {31'd0, w_ltu};
            A_XOR:   w_alu = w_a ^ w_op2;
            A_SRL:   w_alu = w_a >> w_sh;
            A_SRA:   w_alu = $unsigned($signed(w_a) >>> w_sh);
            A_OR:    w_alu = w_a | w_op2;
            default: w_alu = w_a & w_op2;
        endcase
    end

    // Branch condition on the two register operands.
    always_comb begin
        case (i_dec.f3)
            3'd0:    w_cond = (w_a == w_b);
            3'd1:    w_cond = (w_a != w_b);
            3'd4:    w_cond = $signed(w_a) < $signed(w_b);
            3'd5:    w_cond = !($signed(w_a) < $signed(w_b));
            3'd6:    w_cond = w_a < w_b;
            default: w_cond = w_a >= w_b;
        endcase
    end

    // Execute: next pc, writeback and status.
    always_comb begin
        w_ok    = 1'b1;
        w_wr    = 1'b0;
        w_taken = 1'b0;
        w_val   = 32'd0;
        w_npc   = w_pc4;
        case (i_dec.kind)
            K_LUI: begin
                w_wr = 1'b1; w_val = i_dec.imm;
            end
            K_AUIPC: begin
                w_wr = 1'b1; w_val = r_pc + i_dec.imm;
            end
            K_JAL: begin
                w_wr = 1'b1; w_val = w_pc4; w_taken = 1'b1;
                w_npc = r_pc + i_dec.imm;
            end
            K_JALR: begin
                w_wr = 1'b1; w_val = w_pc4; w_taken = 1'b1;
                w_npc = (w_a + i_dec.imm) & ~32'd1;
            end
            K_BRANCH: begin
                if (w_cond) begin
                    w_taken = 1'b1;
                    w_npc   = r_pc + i_dec.imm;
                end
            end
            K_ALU: begin
                w_wr = 1'b1; w_val = w_alu;
            end
            default: w_ok = 1'b0;
        endcase
        if (!w_ok) w_st = ST_ILLEGAL;
        else if (w_taken && w_npc[1:0] != 2'b00) w_st = ST_MISALIGN;
        else w_st = ST_OK;
        if (w_st != ST_OK) begin
            w_npc = r_pc; w_wr = 1'b0; w_taken = 1'b0; w_val = 32'd0;
        end
        if (i_dec.rd == 5'd0) w_wr = 1'b0;
    end

    assign o_dec_ready = !r_ov || i_ready;
    assign w_fire      = i_dec_valid && o_dec_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;

    // Control state: pc and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 32'd0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_valid) r_pc <= {i_cfg_data[31:2], 2'b00};
            else if (w_fire) r_pc <= w_npc;
            if (w_fire) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    // Register file, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) r_rf[i] <= 32'd0;
        end else if (w_fire && w_wr) begin
            r_rf[i_dec.rd] <= w_val;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_next_pc      <= w_npc;
            o_write_enable <= w_wr;
            o_dest_reg     <= w_wr ? i_dec.rd : 5'd0;
            o_write_value  <= w_wr ? $signed(w_val) : 32'sd0;
            o_branch_taken <= w_taken;
            o_status       <= w_st;
        end
    end

endmodule

// ===== hdl/rv32i_integer_core_step_top.sv =====
// RV32I step core: one instruction word in, one result item out. Each item
// is decoded in the front end, held in the decode queue, and executed by the
// back end into its result register; throughput is one item per cycle while
// the receiver takes results. A start_pc write loads the pc (low two bits
// cleared). Loads, stores and system encodings report illegal.
// Depends on rvcore_pkg, rvcore_front and rvcore_back.
module rv32i_integer_core_step_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_start_pc,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_instruction,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_next_pc,
    output logic               o_write_enable,
    output logic [4:0]         o_dest_reg,
    output logic signed [31:0] o_write_value,
    output logic               o_branch_taken,
    output logic [1:0]         o_status
);
    import rvcore_pkg::*;

    t_dec w_dec;
    logic w_dec_valid;
    logic w_dec_ready;

    rvcore_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_instruction,
        .o_dec_valid(w_dec_valid), .i_dec_ready(w_dec_ready), .o_dec(w_dec)
    );

    rvcore_back u_back (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_data(i_start_pc),
        .i_dec_valid(w_dec_valid), .o_dec_ready(w_dec_ready), .i_dec(w_dec),
        .o_valid, .i_ready, .o_next_pc, .o_write_enable, .o_dest_reg,
        .o_write_value, .o_branch_taken, .o_status
    );

endmodule

// ===== hdl/rvcore_checker.sv =====
// Port-level checker for the RV32I step core, bound to the top level.
// Depends on rvcore_pkg and the rv32i_integer_core_step_top ports.
module rvcore_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_next_pc,
    input logic        o_write_enable,
    input logic [4:0]  o_dest_reg,
    input logic [31:0] o_write_value,
    input logic        o_branch_taken,
    input logic [1:0]  o_status
);
    import rvcore_pkg::*;

    // A result item stays offered until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_pc))
        else $error("result item dropped while stalled");

    // A write never names x0.
    a_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_enable |-> o_dest_reg != 5'd0)
        else $error("write to x0 reported");

    // A faulting item writes nothing and does not redirect.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> !o_write_enable && !o_branch_taken)
        else $error("faulting item has side effects");

    // No write means no value.
    a_noval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_enable |-> o_write_value == 32'd0 && o_dest_reg == 5'd0)
        else $error("stray writeback fields");

    // Status 3 is never produced and reported pcs are word aligned.
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3 && o_next_pc[1:0] == 2'b00)
        else $error("bad status or unaligned pc");
endmodule

bind rv32i_integer_core_step_top rvcore_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_next_pc, .o_write_enable,
    .o_dest_reg, .o_write_value, .o_branch_taken, .o_status
);

// ===== dv/tb.sv =====
// Self-checking testbench for the RV32I step core: directed table, then
// constrained-by-hand random instruction streams checked against a predictor.
// Depends on rvcore_pkg and rv32i_integer_core_step_top.
module tb;
    import rvcore_pkg::*;

    localparam int NUM_RANDOM  = 1330;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 20;
    localparam int MAX_REPORTS = 10;

    // One expected result item.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        write_enable;
        logic [4:0]  dest_reg;
        logic [31:0] write_value;
        logic        branch_taken;
        logic [1:0]  status;
    } t_result;

    // One directed row: instruction, and whether a typed-in result applies.
    typedef struct {
        logic [31:0] instr;
        bit          typed;
        t_result     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_start_pc;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_instruction;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_next_pc;
    logic        o_write_enable;
    logic [4:0]  o_dest_reg;
    logic signed [31:0] o_write_value;
    logic        o_branch_taken;
    logic [1:0]  o_status;

    // Predictor state.
    logic [31:0] gpr [32];
    logic [31:0] pc_model;

    t_result results_due[$];
    int      mismatch_count;
    int      reported;
    int      idle_cycles;
    bit      timed_out;
    bit      rx_stall_long;

    rv32i_integer_core_step_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_start_pc(i_start_pc),
        .i_valid(i_valid), .o_ready(o_ready), .i_instruction(i_instruction),
        .o_valid(o_valid), .i_ready(i_ready), .o_next_pc(o_next_pc),
        .o_write_enable(o_write_enable), .o_dest_reg(o_dest_reg),
        .o_write_value(o_write_value), .o_branch_taken(o_branch_taken),
        .o_status(o_status)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] sx(logic [31:0] v, int bits);
        logic [31:0] m;
        m = 32'd1 << (bits - 1);
        v = v & ((m << 1) - 1);
        return (v ^ m) - m;
    endfunction

    function automatic bit slt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Executes one instruction on the predictor state and returns its result.
    function automatic t_result execute_instr(logic [31:0] ins);
        t_result r;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, immi, imm, npc, val;
        bit wr, taken, ok, c;
        logic [1:0] st;
        opc = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = gpr[ins[19:15]];
        b = gpr[ins[24:20]];
        immi = sx({20'd0, ins[31:20]}, 12);
        npc = pc_model + 4;
        val = 0;
        wr = 0;
        taken = 0;
        ok = 1;
        c = 0;
        case (opc)
            OPC_LUI: begin
                val = {ins[31:12], 12'd0};
                wr = 1;
            end
            OPC_AUIPC: begin
                val = pc_model + {ins[31:12], 12'd0};
                wr = 1;
            end
            OPC_JAL: begin
                imm = {11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                npc = pc_model + sx(imm, 21);
                val = pc_model + 4;
                wr = 1;
                taken = 1;
            end
            OPC_JALR: begin
                if (f3 != 0) begin
                    ok = 0;
                end else begin
                    npc = (a + immi) & ~32'd1;
                    val = pc_model + 4;
                    wr = 1;
                    taken = 1;
                end
            end
            OPC_BRANCH: begin
                imm = {19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                case (f3)
                    3'd0: c = (a == b);
                    3'd1: c = (a != b);
                    3'd4: c = slt(a, b);
                    3'd5: c = !slt(a, b);
                    3'd6: c = (a < b);
                    3'd7: c = (a >= b);
                    default: ok = 0;
                endcase
                if (ok && c) begin
                    npc = pc_model + sx(imm, 13);
                    taken = 1;
                end
            end
            OPC_OPIMM: begin
                wr = 1;
                case (f3)
                    3'd0: val = a + immi;
                    3'd2: val = slt(a, immi);
                    3'd3: val = (a < immi);
                    3'd4: val = a ^ immi;
                    3'd6: val = a | immi;
                    3'd7: val = a & immi;
                    3'd1: begin
                        if (f7 != F7_BASE) ok = 0;
                        else val = a << ins[24:20];
                    end
                    default: begin
                        if (f7 == F7_BASE) val = a >> ins[24:20];
                        else if (f7 == F7_ALT) val = $signed(a) >>> ins[24:20];
                        else ok = 0;
                    end
                endcase
            end
            OPC_OP: begin
                wr = 1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0: val = a + b;
                        3'd1: val = a << b[4:0];
                        3'd2: val = slt(a, b);
                        3'd3: val = (a < b);
                        3'd4: val = a ^ b;
                        3'd5: val = a >> b[4:0];
                        3'd6: val = a | b;
                        default: val = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    val = a - b;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    val = $signed(a) >>> b[4:0];
                end else begin
                    ok = 0;
                end
            end
            default: ok = 0;
        endcase
        st = ST_OK;
        if (!ok) st = ST_ILLEGAL;
        else if (taken && npc[1:0] != 2'b00) st = ST_MISALIGN;
        if (st != ST_OK) begin
            npc = pc_model;
            wr = 0;
            taken = 0;
            val = 0;
        end else begin
            pc_model = npc;
            if (wr && rd != 0) gpr[rd] = val;
        end
        if (!wr || rd == 0) begin
            wr = 0;
            rd = 0;
            val = 0;
        end
        r.next_pc = npc;
        r.write_enable = wr;
        r.dest_reg = rd;
        r.write_value = val;
        r.branch_taken = taken;
        r.status = st;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, often none.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random register index biased to a few registers so values get reused.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 31);
        return $urandom_range(0, 5);
    endfunction

    // Builds a random instruction, mostly legal encodings with random content.
    function automatic logic [31:0] random_instr();
        logic [31:0] ins;
        int sel;
        logic [6:0] f7;
        logic [2:0] f3;
        ins = $urandom();
        sel = $urandom_range(0, 99);
        if (sel < 8) return ins;
        if (sel < 14) begin
            ins[6:0] = OPC_LUI;
        end else if (sel < 18) begin
            ins[6:0] = OPC_AUIPC;
        end else if (sel < 24) begin
            ins[6:0] = OPC_JAL;
            if ($urandom_range(0, 3) != 0) ins[21] = 1'b0;
        end else if (sel < 30) begin
            ins[6:0] = OPC_JALR;
            if ($urandom_range(0, 4) != 0) ins[14:12] = 3'd0;
            if ($urandom_range(0, 1)) ins[21:20] = 2'b00;
        end else if (sel < 44) begin
            ins[6:0] = OPC_BRANCH;
            if ($urandom_range(0, 3) != 0) ins[8] = 1'b0;
        end else if (sel < 72) begin
            ins[6:0] = OPC_OPIMM;
            f3 = ins[14:12];
            if (f3 == 3'd1 && $urandom_range(0, 7) != 0) ins[31:25] = F7_BASE;
            if (f3 == 3'd5 && $urandom_range(0, 7) != 0)
                ins[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
        end else begin
            ins[6:0] = OPC_OP;
            if ($urandom_range(0, 7) != 0) begin
                f7 = ($urandom_range(0, 2) == 0) ? F7_ALT : F7_BASE;
                if (f7 == F7_ALT) ins[14:12] = $urandom_range(0, 1) ? 3'd0 : 3'd5;
                ins[31:25] = f7;
            end
        end
        ins[19:15] = pick_reg();
        ins[24:20] = (ins[6:0] == OPC_OP || ins[6:0] == OPC_BRANCH) ? pick_reg() : ins[24:20];
        ins[11:7] = pick_reg();
        return ins;
    endfunction

    task automatic write_start_pc(logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_start_pc <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        pc_model = value & ~32'd3;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_start_pc <= $urandom();
    endtask

    // Offers one item, waits for acceptance, queues its expected result.
    // Valid is dropped only when a gap precedes the item, so back-to-back items keep it high.
    task automatic send_instr(logic [31:0] ins, bit typed, t_result typed_res);
        t_result r;
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_instruction <= $urandom();
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_instruction <= ins;
        do @(posedge i_clk); while (!o_ready);
        r = execute_instr(ins);
        results_due.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Receiver: random stalls, then checks each accepted result.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_stall_long) begin
            i_ready <= ($urandom_range(0, 29) == 0);
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 199) == 0) rx_stall_long <= ~rx_stall_long;
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.next_pc = o_next_pc;
            got.write_enable = o_write_enable;
            got.dest_reg = o_dest_reg;
            got.write_value = o_write_value;
            got.branch_taken = o_branch_taken;
            got.status = o_status;
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("Unexpected result item: pc=%h", o_next_pc);
                end
            end else begin
                exp_r = results_due.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (reported < MAX_REPORTS) begin
                        reported++;
                        $display("Mismatch: expected pc=%h we=%b rd=%0d val=%h br=%b st=%0d",
                            exp_r.next_pc, exp_r.write_enable, exp_r.dest_reg,
                            exp_r.write_value, exp_r.branch_taken, exp_r.status);
                        $display("          actual   pc=%h we=%b rd=%0d val=%h br=%b st=%0d",
                            got.next_pc, got.write_enable, got.dest_reg,
                            got.write_value, got.branch_taken, got.status);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result builder for the typed-in table rows.
    function automatic t_result mk(logic [31:0] pc, logic we, logic [4:0] rd,
                                   logic [31:0] v, logic br, logic [1:0] st);
        t_result r;
        r = '{pc, we, rd, v, br, st};
        return r;
    endfunction

    // Stimulus.
    initial begin
        t_row rows[$];
        t_result none;
        none = '0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_start_pc = '0;
        i_valid = 1'b0;
        i_instruction = '0;
        i_ready = 1'b0;
        rx_stall_long = 1'b0;
        mismatch_count = 0;
        reported = 0;
        timed_out = 0;
        foreach (gpr[k]) gpr[k] = '0;
        pc_model = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; pc starts at zero after reset.
        rows.push_back('{32'hFFFFF0B7, 1, mk(32'h4, 1, 5'd1, 32'hFFFFF000, 0, ST_OK)}); // lui x1
        rows.push_back('{32'h00000037, 1, mk(32'h8, 0, 5'd0, 32'h0, 0, ST_OK)});        // lui x0
        rows.push_back('{32'h00000003, 1, mk(32'h8, 0, 5'd0, 32'h0, 0, ST_ILLEGAL)});   // load
        rows.push_back('{32'h00000023, 1, mk(32'h8, 0, 5'd0, 32'h0, 0, ST_ILLEGAL)});   // store
        rows.push_back('{32'h00000073, 1, mk(32'h8, 0, 5'd0, 32'h0, 0, ST_ILLEGAL)});   // ecall
        rows.push_back('{32'h00000000, 1, mk(32'h8, 0, 5'd0, 32'h0, 0, ST_ILLEGAL)});   // zero
        rows.push_back('{32'hFFFFFFFF, 1, mk(32'h8, 0, 5'd0, 32'h0, 0, ST_ILLEGAL)});   // ones
        rows.push_back('{32'h0020016F, 1, mk(32'h8, 0, 5'd0, 32'h0, 0, ST_MISALIGN)});  // jal +2
        rows.push_back('{32'h7FF00113, 0, none});   // addi x2,x0,2047
        rows.push_back('{32'h80010193, 0, none});   // addi x3,x2,-2048
        rows.push_back('{32'h41F0D213, 0, none});   // srai x4,x1,31
        rows.push_back('{32'h01F0D293, 0, none});   // srli x5,x1,31
        rows.push_back('{32'h01F11313, 0, none});   // slli x6,x2,31
        rows.push_back('{32'h4230D213, 1, mk(32'h1C, 0, 5'd0, 32'h0, 0, ST_ILLEGAL)}); // bad f7
        rows.push_back('{32'hFFF0A393, 0, none});   // slti x7,x1,-1
        rows.push_back('{32'hFFF0B413, 0, none});   // sltiu x8,x1,-1
        rows.push_back('{32'h403104B3, 0, none});   // sub x9,x2,x3
        rows.push_back('{32'h4020D533, 0, none});   // sra x10,x1,x2
        rows.push_back('{32'h0020A5B3, 0, none});   // slt x11,x1,x2
        rows.push_back('{32'h0020B633, 0, none});   // sltu x12,x1,x2
        rows.push_back('{32'h00208463, 0, none});   // beq not taken
        rows.push_back('{32'h00209463, 0, none});   // bne taken +8
        rows.push_back('{32'h0020A063, 0, none});   // branch funct3 2
        rows.push_back('{32'h00410767, 0, none});   // jalr x14,x2,4 (misaligned)
        rows.push_back('{32'h00001767, 0, none});   // jalr funct3 1
        rows.push_back('{32'h00000797, 0, none});   // auipc x15
        rows.push_back('{32'hFFDFF86F, 0, none});   // jal x16,-4
        foreach (rows[k]) send_instr(rows[k].instr, rows[k].typed, rows[k].res);

        // Reset vector extremes, written only while idle.
        wait_drained();
        write_start_pc(32'hFFFFFFFF);
        send_instr(32'h00000013, 1, mk(32'h00000000, 0, 5'd0, 32'h0, 0, ST_OK)); // wraps
        wait_drained();
        write_start_pc(32'h00000000);

        // Random phases with differing reset vectors.
        for (int ph = 0; ph < 5; ph++) begin
            for (int n = 0; n < NUM_RANDOM / 5; n++) begin
                send_instr(random_instr(), 0, none);
                // Hold off once in a while until everything has come back.
                if ($urandom_range(0, 199) == 0) wait_drained();
            end
            wait_drained();
            write_start_pc($urandom());
        end
        wait_drained();

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
